>>> rtl/core/rbs_pkg.sv
// Package for the rolling band statistics block.
// Holds shared widths, register codes, reset values and helper functions.
// No dependencies.
`default_nettype none

package rbs_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int DATA_W         = 24;
    localparam int WL_W           = 7;
    localparam int MULT_W         = 16;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam int SQR_W          = 2 * DATA_W;
    localparam int SQRT_STEPS     = SQR_W / 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [WL_W-1:0]   WL_RESET   = 7'd20;
    localparam logic [MULT_W-1:0] MULT_RESET = 16'd8192;

    localparam logic [0:0] REG_WINDOW = 1'b0;
    localparam logic [0:0] REG_MULT   = 1'b1;

    function automatic int cnt_w(input int max_window);
        return $clog2(max_window + 1);
    endfunction

    function automatic int sum_w(input int max_window);
        return DATA_W + cnt_w(max_window);
    endfunction

    function automatic int sq_w(input int max_window);
        return 2 * DATA_W - 2 + cnt_w(max_window);
    endfunction

    function automatic int ent_w(input int max_window);
        return 1 + sum_w(max_window) + sq_w(max_window) + cnt_w(max_window);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_s24(input logic signed [DATA_W+5:0] v);
        logic signed [DATA_W+5:0] hi;
        logic signed [DATA_W+5:0] lo;
        hi = (DATA_W+6)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = (DATA_W+6)'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > hi)
        begin
            return hi[DATA_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rolling_band_statistics_top.sv
// Rolling band statistics: top level with the APB register port.
// Usage: samples are pushed with push/full; a sample is taken when push is
// high and full is low. Each sample yields exactly one result word, read
// through empty/pop in order; the word on the result ports stays until pop.
// Register 0 (address 0) is window_length, register 1 (address 4) is
// band_multiplier. Writing window_length restarts the window.
// The front takes one sample at a time (ring read, two squares, update);
// the back works on one word at a time with its one-bit-per-cycle
// divider and two-bit-per-cycle square root. Sustained throughput is
// therefore one sample per back pass.
// A two-word queue separates front and back, so the front keeps taking
// samples while the back works or while a result waits to be popped.
// When the receiver stalls, the queue fills and full rises.
// Reset clears the counts and sums and loads the register defaults; the
// ring needs no clearing because entries are only read once written.
// Depends on rbs_pkg, rbs_front, rbs_queue and rbs_back.
`default_nettype none

module rolling_band_statistics_top #(
    parameter int MAX_WINDOW = rbs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbs_pkg::APB_AW-1:0]          paddr,
    input  logic [rbs_pkg::APB_DW-1:0]          pwdata,
    output logic [rbs_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic signed [rbs_pkg::DATA_W-1:0]   sample,
    input  logic                                sample_valid,
    output logic                                empty,
    input  logic                                pop,
    output logic                                bands_valid,
    output logic signed [rbs_pkg::DATA_W-1:0]   middle_band,
    output logic signed [rbs_pkg::DATA_W-1:0]   upper_band,
    output logic signed [rbs_pkg::DATA_W-1:0]   lower_band,
    output logic [rbs_pkg::DATA_W-1:0]          band_width
);
    import rbs_pkg::*;

    localparam int EW = ent_w(MAX_WINDOW);

    logic [WL_W-1:0]   wl_reg;
    logic [MULT_W-1:0] mult_reg;
    logic              wr_en;
    logic              clear;
    logic              front_idle;
    logic              accept;
    logic              q_push;
    logic [EW-1:0]     q_wdata;
    logic              q_full;
    logic              q_pop;
    logic [EW-1:0]     q_rdata;
    logic              q_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign clear  = wr_en && (paddr[2] == REG_WINDOW);
    assign full   = !front_idle || q_full;
    assign accept = push && !full;

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW: prdata = APB_DW'(wl_reg);
            REG_MULT:   prdata = APB_DW'(mult_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= WL_RESET;
            mult_reg <= MULT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WINDOW: wl_reg   <= pwdata[WL_W-1:0];
                REG_MULT:   mult_reg <= pwdata[MULT_W-1:0];
                default:    wl_reg   <= wl_reg;
            endcase
        end
    end

    rbs_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sample        (sample),
        .sample_valid  (sample_valid),
        .window_length (wl_reg),
        .clear         (clear),
        .idle          (front_idle),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    rbs_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    rbs_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_data          (q_rdata),
        .band_multiplier (mult_reg),
        .pop             (pop),
        .empty           (empty),
        .bands_valid     (bands_valid),
        .middle_band     (middle_band),
        .upper_band      (upper_band),
        .lower_band      (lower_band),
        .band_width      (band_width)
    );

endmodule

`default_nettype wire

>>> rtl/core/rbs_queue.sv
// Short word queue between the front and back parts of the band block.
// Depends on rbs_pkg for the default depth.
`default_nettype none

module rbs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rbs_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  store_reg [DEPTH];
    logic [IW-1:0] wr_ptr_reg;
    logic [IW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(DEPTH)) && !do_pop |=> (count_reg == CW'(DEPTH)))
        else $error("Queue count changed while full without a pop.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !do_push |=> empty)
        else $error("Queue became non-empty without a push.");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Queue count beyond depth.");

endmodule

`default_nettype wire

>>> rtl/core/rbs_front.sv
// Front part of the band block: sample ring, running sums and counts.
// Depends on rbs_pkg; feeds one word per sample into rbs_queue.
`default_nettype none

module rbs_front #(
    parameter int MAX_WINDOW = rbs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic signed [rbs_pkg::DATA_W-1:0]        sample,
    input  logic                                     sample_valid,
    input  logic [rbs_pkg::WL_W-1:0]                 window_length,
    input  logic                                     clear,
    output logic                                     idle,
    output logic                                     q_push,
    output logic [rbs_pkg::ent_w(MAX_WINDOW)-1:0]    q_data
);
    import rbs_pkg::*;

    localparam int CNT_W = cnt_w(MAX_WINDOW);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = sum_w(MAX_WINDOW);
    localparam int SQ_W  = sq_w(MAX_WINDOW);
    localparam int LW    = ((CNT_W > WL_W) ? CNT_W : WL_W) + 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RD   = 2'd1;
    localparam logic [1:0] F_SQ   = 2'd2;
    localparam logic [1:0] F_UPD  = 2'd3;

    logic [DATA_W:0]           ring_mem [MAX_WINDOW];
    logic [DATA_W:0]           rd_q_reg;
    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [PTR_W-1:0]          wp_reg;
    logic [PTR_W-1:0]          wp_next;
    logic [CNT_W-1:0]          seen_reg;
    logic [CNT_W-1:0]          seen_next;
    logic [CNT_W-1:0]          vc_reg;
    logic [CNT_W-1:0]          vc_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W-1:0]           sq_next;
    logic signed [DATA_W-1:0]  x_reg;
    logic                      v_reg;
    logic                      drop_reg;
    logic [SQR_W-1:0]          xsq_reg;
    logic [SQR_W-1:0]          osq_reg;

    logic [LW-1:0]             wl_ext;
    logic [LW-1:0]             len_l;
    logic [CNT_W-1:0]          len_c;
    logic [CNT_W:0]            wp_ext;
    logic [CNT_W:0]            len_e;
    logic [CNT_W:0]            old_full;
    logic [PTR_W-1:0]          old_addr;
    logic signed [DATA_W-1:0]  old_s;
    logic signed [SQR_W-1:0]   x_prod;
    logic signed [SQR_W-1:0]   o_prod;
    logic                      rm_old;
    logic                      ok;

    assign wl_ext   = LW'(window_length);
    assign len_l    = (wl_ext == '0) ? LW'(1) :
                      ((wl_ext > LW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : wl_ext);
    assign len_c    = len_l[CNT_W-1:0];
    assign wp_ext   = (CNT_W+1)'(wp_reg);
    assign len_e    = (CNT_W+1)'(len_c);
    assign old_full = (wp_ext >= len_e) ? wp_ext - len_e
                                        : wp_ext + (CNT_W+1)'(MAX_WINDOW) - len_e;
    assign old_addr = old_full[PTR_W-1:0];
    assign old_s    = rd_q_reg[DATA_W-1:0];
    assign x_prod   = x_reg * x_reg;
    assign o_prod   = old_s * old_s;
    assign rm_old   = drop_reg && rd_q_reg[DATA_W];
    assign idle     = (state_reg == F_IDLE);

    always_comb
    begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        vc_next  = vc_reg;
        if (rm_old)
        begin
            sum_next = sum_next - SUM_W'(old_s);
            sq_next  = sq_next - SQ_W'(osq_reg);
            if (vc_reg != '0)
            begin
                vc_next = vc_next - 1'b1;
            end
        end
        if (v_reg)
        begin
            sum_next = sum_next + SUM_W'(x_reg);
            sq_next  = sq_next + SQ_W'(xsq_reg);
            vc_next  = vc_next + 1'b1;
        end
        seen_next = (seen_reg == CNT_W'(MAX_WINDOW)) ? seen_reg : seen_reg + 1'b1;
        wp_next   = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
    end

    assign ok     = (seen_next >= len_c) && (vc_next > CNT_W'(1));
    assign q_push = (state_reg == F_UPD);
    assign q_data = {ok, sum_next, sq_next, vc_next};

    always_comb
    begin
        case (state_reg)
            F_IDLE:  state_next = accept ? F_RD : F_IDLE;
            F_RD:    state_next = F_SQ;
            F_SQ:    state_next = F_UPD;
            F_UPD:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_UPD)
        begin
            ring_mem[wp_reg] <= {v_reg, v_reg ? x_reg : {DATA_W{1'b0}}};
        end
        if (accept)
        begin
            rd_q_reg <= ring_mem[old_addr];
            x_reg    <= sample;
            v_reg    <= sample_valid;
            drop_reg <= (seen_reg >= len_c);
        end
        if (state_reg == F_RD)
        begin
            xsq_reg <= $unsigned(x_prod);
        end
        if (state_reg == F_SQ)
        begin
            osq_reg <= $unsigned(o_prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= '0;
            seen_reg  <= '0;
            vc_reg    <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                wp_reg   <= '0;
                seen_reg <= '0;
                vc_reg   <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
            end
            else if (state_reg == F_UPD)
            begin
                wp_reg   <= wp_next;
                seen_reg <= seen_next;
                vc_reg   <= vc_next;
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
            end
        end
    end

    a_accept_then_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 q_push)
        else $error("Accepted sample did not reach the queue three cycles later.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= seen_reg)
        else $error("Valid count exceeds the number of samples seen.");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != F_IDLE) |-> !accept)
        else $error("Sample accepted while the front was busy.");

endmodule

`default_nettype wire

>>> rtl/core/rbs_back.sv
// Back part of the band block: divides, integer square root and band output.
// Depends on rbs_pkg; takes words from rbs_queue and holds one result word.
`default_nettype none

module rbs_back #(
    parameter int MAX_WINDOW = rbs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    output logic                                   q_pop,
    input  logic [rbs_pkg::ent_w(MAX_WINDOW)-1:0]  q_data,
    input  logic [rbs_pkg::MULT_W-1:0]             band_multiplier,
    input  logic                                   pop,
    output logic                                   empty,
    output logic                                   bands_valid,
    output logic signed [rbs_pkg::DATA_W-1:0]      middle_band,
    output logic signed [rbs_pkg::DATA_W-1:0]      upper_band,
    output logic signed [rbs_pkg::DATA_W-1:0]      lower_band,
    output logic [rbs_pkg::DATA_W-1:0]             band_width
);
    import rbs_pkg::*;

    localparam int CNT_W  = cnt_w(MAX_WINDOW);
    localparam int SUM_W  = sum_w(MAX_WINDOW);
    localparam int SQ_W   = sq_w(MAX_WINDOW);
    localparam int RW     = CNT_W + 1;
    localparam int STEP_W = $clog2(SQ_W);
    localparam int PROD_W = MULT_W + DATA_W;
    localparam int OFF_W  = PROD_W - 12;
    localparam int WID_W  = PROD_W - 11;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_MEAN = 3'd2;
    localparam logic [2:0] B_MSQ  = 3'd3;
    localparam logic [2:0] B_VAR  = 3'd4;
    localparam logic [2:0] B_SQRT = 3'd5;
    localparam logic [2:0] B_PROD = 3'd6;
    localparam logic [2:0] B_OUT  = 3'd7;

    logic [2:0]               state_reg;
    logic                     ok_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [SQ_W-1:0]          a_reg;
    logic [SQ_W-1:0]          b_reg;
    logic [RW-1:0]            ra_reg;
    logic [RW-1:0]            rb_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [SQR_W-1:0]         msq_reg;
    logic                     vpos_reg;
    logic [SQR_W-1:0]         v_reg;
    logic [SQR_W-1:0]         res_reg;
    logic [SQR_W-1:0]         bit_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     out_valid_reg;

    logic                     e_ok;
    logic signed [SUM_W-1:0]  e_sum;
    logic [SQ_W-1:0]          e_sq;
    logic [CNT_W-1:0]         e_n;
    logic [SUM_W-1:0]         e_abs;
    logic [RW-1:0]            ra_sh;
    logic [RW-1:0]            rb_sh;
    logic                     ga;
    logic                     gb;
    logic signed [DATA_W:0]   mag_s;
    logic signed [DATA_W:0]   mean_w;
    logic signed [SQR_W-1:0]  mean_prod;
    logic signed [SQ_W:0]     var_s;
    logic [SQR_W-1:0]         trial;
    logic [OFF_W-1:0]         off;
    logic [WID_W-1:0]         wid;
    logic signed [DATA_W+5:0] up_s;
    logic signed [DATA_W+5:0] lo_s;
    logic                     good;
    logic                     out_load;

    assign {e_ok, e_sum, e_sq, e_n} = q_data;
    assign e_abs     = e_sum[SUM_W-1] ? $unsigned(-e_sum) : $unsigned(e_sum);
    assign ra_sh     = {ra_reg[RW-2:0], a_reg[SQ_W-1]};
    assign rb_sh     = {rb_reg[RW-2:0], b_reg[SQ_W-1]};
    assign ga        = (ra_sh >= RW'(n_reg));
    assign gb        = (rb_sh >= RW'(n_reg));
    assign mag_s     = {1'b0, a_reg[DATA_W-1:0]};
    assign mean_w    = neg_reg ? -mag_s : mag_s;
    assign mean_prod = mean_reg * mean_reg;
    assign var_s     = $signed({1'b0, b_reg}) - $signed((SQ_W+1)'(msq_reg));
    assign trial     = res_reg + bit_reg;
    assign off       = prod_reg[PROD_W-1:12];
    assign wid       = prod_reg[PROD_W-1:11];
    assign up_s      = (DATA_W+6)'(mean_reg) + $signed((DATA_W+6)'(off));
    assign lo_s      = (DATA_W+6)'(mean_reg) - $signed((DATA_W+6)'(off));
    assign good      = ok_reg && vpos_reg;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || pop);
    assign empty     = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                ok_reg   <= e_ok;
                neg_reg  <= e_sum[SUM_W-1];
                n_reg    <= e_n;
                a_reg    <= SQ_W'(e_abs);
                b_reg    <= e_sq;
                ra_reg   <= '0;
                rb_reg   <= '0;
                step_reg <= STEP_W'(SQ_W - 1);
            end
            B_DIV:
            begin
                a_reg    <= {a_reg[SQ_W-2:0], ga};
                b_reg    <= {b_reg[SQ_W-2:0], gb};
                ra_reg   <= ga ? ra_sh - RW'(n_reg) : ra_sh;
                rb_reg   <= gb ? rb_sh - RW'(n_reg) : rb_sh;
                step_reg <= step_reg - 1'b1;
            end
            B_MEAN:
            begin
                mean_reg <= mean_w[DATA_W-1:0];
            end
            B_MSQ:
            begin
                msq_reg <= $unsigned(mean_prod);
            end
            B_VAR:
            begin
                vpos_reg <= !var_s[SQ_W] && (var_s != '0);
                v_reg    <= var_s[SQR_W-1:0];
                res_reg  <= '0;
                bit_reg  <= SQR_W'(1) << (SQR_W - 2);
                step_reg <= STEP_W'(SQRT_STEPS - 1);
            end
            B_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg - 1'b1;
            end
            B_PROD:
            begin
                prod_reg <= band_multiplier * res_reg[DATA_W-1:0];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load)
        begin
            bands_valid <= good;
            middle_band <= good ? mean_reg : '0;
            upper_band  <= good ? sat_s24(up_s) : '0;
            lower_band  <= good ? sat_s24(lo_s) : '0;
            band_width  <= !good ? '0 :
                           ((|wid[WID_W-1:DATA_W]) ? {DATA_W{1'b1}} : wid[DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:  state_reg <= q_empty ? B_IDLE : B_DIV;
                B_DIV:   state_reg <= (step_reg == '0) ? B_MEAN : B_DIV;
                B_MEAN:  state_reg <= B_MSQ;
                B_MSQ:   state_reg <= B_VAR;
                B_VAR:   state_reg <= B_SQRT;
                B_SQRT:  state_reg <= (step_reg == '0) ? B_PROD : B_SQRT;
                B_PROD:  state_reg <= B_OUT;
                B_OUT:   state_reg <= out_load ? B_IDLE : B_OUT;
                default: state_reg <= B_IDLE;
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) && out_valid_reg && !pop |=> (state_reg == B_OUT))
        else $error("Result word overwritten before it was taken.");
    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == B_DIV))
        else $error("Queue word taken but division did not start.");
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == B_IDLE))
        else $error("Result load did not raise the output valid.");

endmodule

`default_nettype wire
